>>> hdl/dgc_pkg.sv
// dgc_pkg: shared types, constants and the crc byte step for the discovery datagram checker
// no dependencies
package dgc_pkg;

	localparam int unsigned POS_W = 10;

	localparam logic [31:0] OUTER_MAGIC = 32'h5454_5431;
	localparam logic [31:0] INNER_MAGIC = 32'h7474_7431;
	localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
	localparam logic [7:0]  MIN_PAYLOAD = 8'd30;
	localparam logic [15:0] TOL_RESET   = 16'd300;

	typedef enum logic [3:0] {
		ST_OK            = 4'd0,
		ST_LENGTH        = 4'd1,
		ST_MAGIC         = 4'd2,
		ST_ENC_TYPE      = 4'd3,
		ST_PLAIN_REFUSED = 4'd4,
		ST_ENCRYPTED     = 4'd5,
		ST_INNER_MAGIC   = 4'd6,
		ST_CRC           = 4'd7,
		ST_STALE         = 4'd8,
		ST_SHORT         = 4'd9
	} status_t;

	typedef enum logic [1:0] {
		CFG_ALLOW_PLAIN = 2'd0,
		CFG_TIME_TOL    = 2'd1
	} cfg_reg_t;

	// everything the verdict needs from one finished datagram
	typedef struct packed {
		logic        len_bad;
		logic        plen_over;
		logic [63:0] header;
		logic [63:0] pf0;
		logic [31:0] crc;
		logic [31:0] stamp;
		logic [15:0] port;
		logic [31:0] now;
	} snap_t;

	// reflected crc-32, one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
		logic [31:0] c;
		c = crc_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

>>> hdl/discovery_datagram_checker.sv
// discovery_datagram_checker: top level with configuration registers
// depends on dgc_pkg, dgc_stream and dgc_judge
//
// Usage:
// - input channel (in_valid/in_ready) takes one datagram byte per item with
//   last_byte marking the final byte; current_time is sampled with that byte
// - one result (status, invite_port) leaves on out_valid/out_ready for
//   each final byte, none for the other bytes
// - throughput is one byte per cycle while in_ready is high; the crc byte
//   update sits between the input register and the datagram state
// - a final byte passes the input register, the snapshot register and the
//   result register before its result shows
// - when the receiver stalls, the result and one finished snapshot are held;
//   non-final bytes keep flowing until a further final byte waits in the
//   input register, then in_ready drops
// - cfg_valid/cfg_ready writes allow_plain (index 0) and time_tolerance
//   (index 1); other indexes are dropped; cfg_ready is always high
// - reset clears the byte state, allow_plain to 0, time_tolerance to 300
module discovery_datagram_checker #(
	parameter int unsigned MAX_DATAGRAM_BYTES = 263
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_value,
	input  logic        last_byte,
	input  logic [31:0] current_time,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  status,
	output logic [15:0] invite_port,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import dgc_pkg::*;

	logic        allow_plain_q;
	logic [15:0] time_tol_q;
	logic        snap_valid;
	logic        snap_ready;
	snap_t       snap;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_plain_q <= 1'b0;
			time_tol_q    <= TOL_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ALLOW_PLAIN: allow_plain_q <= cfg_data[0];
				CFG_TIME_TOL:    time_tol_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	dgc_stream #(
		.MAX_DATAGRAM_BYTES(MAX_DATAGRAM_BYTES)
	) u_stream (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.byte_value   (byte_value),
		.last_byte    (last_byte),
		.current_time (current_time),
		.snap_valid   (snap_valid),
		.snap_ready   (snap_ready),
		.snap         (snap)
	);

	dgc_judge u_judge (
		.clk             (clk),
		.arst_n          (arst_n),
		.snap_valid      (snap_valid),
		.snap_ready      (snap_ready),
		.snap            (snap),
		.allow_plain     (allow_plain_q),
		.time_tolerance  (time_tol_q),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.invite_port     (invite_port)
	);

endmodule

>>> hdl/dgc_stream.sv
// dgc_stream: input register and per-byte datagram state (header, payload fields, crc)
// depends on dgc_pkg; hands a snapshot of each finished datagram to dgc_judge
module dgc_stream #(
	parameter int unsigned MAX_DATAGRAM_BYTES = 263
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    byte_value,
	input  logic          last_byte,
	input  logic [31:0]   current_time,
	output logic          snap_valid,
	input  logic          snap_ready,
	output dgc_pkg::snap_t snap
);
	import dgc_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_DATAGRAM_BYTES + 2);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DATAGRAM_BYTES);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_DATAGRAM_BYTES);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic [31:0]       now_s1;

	logic [CNT_W-1:0]  count_q, count_d;
	logic [63:0]       header_q, header_d;
	logic [63:0]       pf0_q, pf0_d;
	logic [31:0]       crc_q, crc_d;
	logic [31:0]       stamp_q, stamp_d;
	logic [15:0]       port_q, port_d;

	logic              snap_valid_s2;
	snap_t             snap_s2;
	snap_t             snap_d;

	logic              go;
	logic [POS_W-1:0]  pos_w, end_w, total_w, plen_end_w;

	assign go       = valid_s1 && (!last_s1 || !snap_valid_s2 || snap_ready);
	assign in_ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= byte_value;
			last_s1 <= last_byte;
			now_s1  <= current_time;
		end
	end

	always_comb begin
		pos_w    = POS_W'(count_q);
		end_w    = POS_W'(header_q[7:0]) + POS_W'(8);
		header_d = header_q;
		pf0_d    = pf0_q;
		crc_d    = crc_q;
		stamp_d  = stamp_q;
		port_d   = port_q;
		if (pos_w < POS_MAX) begin
			if (pos_w < POS_W'(8)) begin
				header_d = {header_q[55:0], byte_s1};
			end else begin
				if (pos_w < POS_W'(16)) begin
					pf0_d = {pf0_q[55:0], byte_s1};
				end else if (pos_w < end_w) begin
					crc_d = crc_byte(crc_q, byte_s1);
				end
				if (pos_w >= POS_W'(32) && pos_w < POS_W'(36)) begin
					stamp_d = {stamp_q[23:0], byte_s1};
				end else if (pos_w >= POS_W'(36) && pos_w < POS_W'(38)) begin
					port_d = {port_q[7:0], byte_s1};
				end
			end
		end
		// count saturates one past the maximum so oversize datagrams stay visible
		count_d = (count_q <= CNT_MAX) ? count_q + CNT_W'(1) : count_q;

		total_w    = POS_W'(count_d);
		plen_end_w = POS_W'(header_d[7:0]) + POS_W'(8);

		snap_d.len_bad   = (total_w < POS_W'(8)) || (total_w > POS_MAX);
		snap_d.plen_over = plen_end_w > total_w;
		snap_d.header    = header_d;
		snap_d.pf0       = pf0_d;
		snap_d.crc       = crc_d;
		snap_d.stamp     = stamp_d;
		snap_d.port      = port_d;
		snap_d.now       = now_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			header_q <= '0;
			pf0_q    <= '0;
			crc_q    <= CRC_INIT;
			stamp_q  <= '0;
			port_q   <= '0;
		end else if (go) begin
			if (last_s1) begin
				count_q  <= '0;
				header_q <= '0;
				pf0_q    <= '0;
				crc_q    <= CRC_INIT;
				stamp_q  <= '0;
				port_q   <= '0;
			end else begin
				count_q  <= count_d;
				header_q <= header_d;
				pf0_q    <= pf0_d;
				crc_q    <= crc_d;
				stamp_q  <= stamp_d;
				port_q   <= port_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s2 <= 1'b0;
		end else if (go && last_s1) begin
			snap_valid_s2 <= 1'b1;
		end else if (snap_ready) begin
			snap_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && last_s1) begin
			snap_s2 <= snap_d;
		end
	end

	assign snap_valid = snap_valid_s2;
	assign snap       = snap_s2;

endmodule

>>> hdl/dgc_judge.sv
// dgc_judge: ordered checks on a finished datagram and the result register
// depends on dgc_pkg; fed by dgc_stream
module dgc_judge (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           snap_valid,
	output logic           snap_ready,
	input  dgc_pkg::snap_t snap,
	input  logic           allow_plain,
	input  logic [15:0]    time_tolerance,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [3:0]     status,
	output logic [15:0]    invite_port
);
	import dgc_pkg::*;

	logic        out_valid_q;
	status_t     status_q, status_d;
	logic [15:0] port_q, port_d;
	logic [31:0] diff, mag;
	logic [15:0] enc;

	assign snap_ready = !out_valid_q || out_ready;

	always_comb begin
		enc  = snap.header[31:16];
		diff = snap.now - snap.stamp;
		mag  = diff[31] ? (32'd0 - diff) : diff;
		priority if (snap.len_bad) begin
			status_d = ST_LENGTH;
		end else if (snap.header[63:32] != OUTER_MAGIC) begin
			status_d = ST_MAGIC;
		end else if (enc > 16'd1) begin
			status_d = ST_ENC_TYPE;
		end else if (enc == 16'd1) begin
			status_d = ST_ENCRYPTED;
		end else if (!allow_plain) begin
			status_d = ST_PLAIN_REFUSED;
		end else if (snap.header[7:0] < MIN_PAYLOAD || snap.plen_over) begin
			status_d = ST_SHORT;
		end else if (snap.pf0[63:32] != INNER_MAGIC) begin
			status_d = ST_INNER_MAGIC;
		end else if (snap.pf0[31:0] != ~snap.crc) begin
			status_d = ST_CRC;
		end else if (mag > {16'd0, time_tolerance}) begin
			status_d = ST_STALE;
		end else begin
			status_d = ST_OK;
		end
		port_d = (status_d == ST_OK) ? snap.port : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (snap_ready) begin
			out_valid_q <= snap_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_ready && snap_valid) begin
			status_q <= status_d;
			port_q   <= port_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign invite_port = port_q;

endmodule

>>> hdl/dgc_checker.sv
// dgc_checker: port-level assertions for discovery_datagram_checker
// depends on dgc_pkg; bound to the top level below
module dgc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  status,
	input logic [15:0] invite_port,
	input logic        cfg_ready
);
	import dgc_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(invite_port))
		else $error("result changed while stalled");

	// port is only reported for a clean datagram
	a_port_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> invite_port == 16'd0)
		else $error("port nonzero on failed datagram");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_SHORT)
		else $error("status code out of range");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind discovery_datagram_checker dgc_checker u_dgc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.status          (status),
	.invite_port     (invite_port),
	.cfg_ready       (cfg_ready)
);
